// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL of the health logger.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When the condition is seen, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/hslog_pkg.sv -----
// ----------------------------------------------------------------------------
// hslog_pkg
// Types and constants for the health sample change logger.
// ----------------------------------------------------------------------------
package hslog_pkg;

  localparam int RING_SLOTS_DEF = 17;
  localparam int SLOT_FIELD_W   = 5;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_IDX_W      = 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_THR      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RSSI_THR      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_COUNT   = 3'd4;

  // Register reset values.
  localparam logic [31:0] PERIOD_RST    = 32'd30000;
  localparam logic [31:0] HEARTBEAT_RST = 32'd300000;
  localparam logic [15:0] HEAP_THR_RST  = 16'd512;
  localparam logic [7:0]  RSSI_THR_RST  = 8'd6;
  localparam logic [31:0] START_RST     = 32'd0;

  localparam logic [15:0] SAT16_MAX = 16'hFFFF;

  // Exact unsigned division by 1000 of any 32-bit value: (x * M) >> 38.
  localparam logic [31:0] DIV1000_MAGIC = 32'h10624DD3;
  localparam int          DIV1000_SHIFT = 38;
  localparam int          UPTIME_W      = 23;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic [31:0]        free_heap;
    logic [31:0]        largest_block;
    logic [31:0]        link_drops;
    logic signed [7:0]  signal_strength;
    logic [7:0]         link_status;
  } sample_t;

  typedef struct packed {
    logic [SLOT_FIELD_W-1:0] slot;
    logic [UPTIME_W-1:0]     uptime_s;
    logic [15:0]             heap_sat;
    logic [15:0]             block_sat;
    logic signed [7:0]       rssi_out;
    logic [7:0]              status_out;
    logic [15:0]             drops_sat;
    logic [31:0]             entries_written;
  } entry_t;

  function automatic logic [15:0] sat16(input logic [31:0] v);
    return (v > 32'(SAT16_MAX)) ? SAT16_MAX : v[15:0];
  endfunction

endpackage

// ----- hw/rtl/health_sample_change_logger.sv -----
// An accepted request waits in the input register; an entry it writes goes
// to the result register and out_valid. Throughput: one request per cycle,
// set by the single compare stage that holds and updates the logger state.
// An entry-writing request waits while the previous entry is held at output.
// Reset (synchronous, active high) restores all but in_q, out_q to defaults.
// ----------------------------------------------------------------------------
// health_sample_change_logger
// Deadband change reporting of health samples with a heartbeat entry.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module health_sample_change_logger
  import hslog_pkg::*;
#(
  parameter int RING_SLOTS = RING_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sample_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output entry_t                out_data
);

  // Width of the ring slot counter; at least one bit.
  localparam int SLOT_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;

  // Reciprocal of the ring size: q = (x * MOD_MAGIC) >> (32 + MOD_L) is the
  // exact quotient of any 32-bit x by the ring size.
  localparam int          MOD_L          = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 0;
  localparam logic [63:0] MOD_NUM        = 64'd1 << (32 + MOD_L);
  localparam logic [63:0] MOD_MAGIC_FULL = (MOD_NUM + 64'(RING_SLOTS) - 64'd1)
                                           / 64'(RING_SLOTS);
  localparam logic [32:0] MOD_MAGIC      = MOD_MAGIC_FULL[32:0];

  // Configuration registers.
  logic [31:0] cfg_period;
  logic [31:0] cfg_heartbeat;
  logic [15:0] cfg_heap_thr;
  logic [7:0]  cfg_rssi_thr;
  logic [31:0] cfg_start;

  // Ring slot of the start count: the quotient is registered when start_count
  // is written, and the remainder follows from it combinationally.
  logic [71:0]       start_prod;
  logic [31:0]       start_quot;
  logic [31:0]       start_rem;
  logic [SLOT_W-1:0] start_mod;

  // Logger state.
  logic              started;
  logic [31:0]       next_due_ms;
  logic [31:0]       entry_count;
  logic [SLOT_W-1:0] slot_cnt;
  logic [31:0]       last_write_ms;
  logic [15:0]       last_heap;
  logic [15:0]       last_block;
  logic signed [7:0] last_rssi;
  logic [7:0]        last_status;
  logic [15:0]       last_drops;

  // Input register and result register.
  sample_t in_q;
  logic    in_vld;
  entry_t  out_q;
  logic    out_vld;

  // Stage logic.
  logic [31:0]       due_diff;
  logic              early;
  logic              take;
  logic [15:0]       heap_s;
  logic [15:0]       block_s;
  logic [15:0]       drops_s;
  logic [15:0]       heap_diff;
  logic [15:0]       block_diff;
  logic signed [8:0] rssi_sdiff;
  logic [8:0]        rssi_diff;
  logic [31:0]       count_eff;
  logic [SLOT_W-1:0] slot_eff;
  logic [SLOT_W-1:0] slot_next;
  logic              changed;
  logic              hb_due;
  logic              emit;
  logic              out_free;
  logic              stage_go;
  logic [63:0]       div_prod;
  logic [SLOT_W+SLOT_FIELD_W-1:0] slot_ext;

  assign start_prod = 72'(cfg_wdata) * 72'(MOD_MAGIC);

  // ---------------------------------------------------------------------------
  // Configuration registers. Indexes beyond the list are ignored.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_period    <= PERIOD_RST;
      cfg_heartbeat <= HEARTBEAT_RST;
      cfg_heap_thr  <= HEAP_THR_RST;
      cfg_rssi_thr  <= RSSI_THR_RST;
      cfg_start     <= START_RST;
      start_quot    <= '0;   // the reset start count is zero, so is its quotient
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_SAMPLE_PERIOD: cfg_period    <= cfg_wdata;
        REG_HEARTBEAT:     cfg_heartbeat <= cfg_wdata;
        REG_HEAP_THR:      cfg_heap_thr  <= cfg_wdata[15:0];
        REG_RSSI_THR:      cfg_rssi_thr  <= cfg_wdata[7:0];
        REG_START_COUNT: begin
          cfg_start  <= cfg_wdata;
          start_quot <= 32'(start_prod >> (32 + MOD_L));
        end
        default: ;
      endcase
    end
  end

  // The remainder is below the ring size, so the low bits of the wrapped
  // difference hold it exactly.
  assign start_rem = cfg_start - start_quot * 32'(RING_SLOTS);
  assign start_mod = start_rem[SLOT_W-1:0];

  // ---------------------------------------------------------------------------
  // Decision logic on the registered request.
  // ---------------------------------------------------------------------------
  always_comb begin
    // A request is early when it lands before the due time, taken wrap-safely.
    due_diff = in_q.now_ms - next_due_ms;
    early    = started && due_diff[31];
    take     = in_vld && !early;

    heap_s  = sat16(in_q.free_heap);
    block_s = sat16(in_q.largest_block);
    drops_s = sat16(in_q.link_drops);

    heap_diff  = (heap_s >= last_heap) ? (heap_s - last_heap) : (last_heap - heap_s);
    block_diff = (block_s >= last_block) ? (block_s - last_block)
                                         : (last_block - block_s);
    rssi_sdiff = 9'(in_q.signal_strength) - 9'(last_rssi);
    rssi_diff  = rssi_sdiff[8] ? 9'(-rssi_sdiff) : 9'(rssi_sdiff);

    // Before the first sample the count and slot come from start_count.
    count_eff = started ? entry_count : cfg_start;
    slot_eff  = started ? slot_cnt : start_mod;

    changed = (count_eff == '0) ||
              (heap_diff >= cfg_heap_thr) ||
              (block_diff >= cfg_heap_thr) ||
              (in_q.link_status != last_status) ||
              (drops_s != last_drops) ||
              (rssi_diff >= {1'b0, cfg_rssi_thr});
    hb_due  = (in_q.now_ms - last_write_ms) >= cfg_heartbeat;
    emit    = take && (changed || hb_due);

    // The slot follows the count modulo the ring size; when the 32-bit count
    // wraps to zero, the slot restarts at zero as well.
    if (count_eff == '1 || slot_eff == SLOT_W'(RING_SLOTS - 1)) begin
      slot_next = '0;
    end else begin
      slot_next = slot_eff + 1'b1;
    end

    out_free = !out_vld || out_ready;
    stage_go = in_vld && (!emit || out_free);

    div_prod = 64'(in_q.now_ms) * 64'(DIV1000_MAGIC);
    slot_ext = {{SLOT_FIELD_W{1'b0}}, slot_eff};
  end

  assign in_ready = !in_vld || stage_go;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ready) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Logger state. The due time moves on with every sample that is not early;
  // the last-written values move only when an entry is written.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      started       <= 1'b0;
      next_due_ms   <= '0;
      entry_count   <= '0;
      slot_cnt      <= '0;
      last_write_ms <= '0;
      last_heap     <= '0;
      last_block    <= '0;
      last_rssi     <= '0;
      last_status   <= '0;
      last_drops    <= '0;
    end else if (stage_go && take) begin
      started     <= 1'b1;
      next_due_ms <= in_q.now_ms + cfg_period;
      if (emit) begin
        entry_count   <= count_eff + 32'd1;
        slot_cnt      <= slot_next;
        last_write_ms <= in_q.now_ms;
        last_heap     <= heap_s;
        last_block    <= block_s;
        last_rssi     <= in_q.signal_strength;
        last_status   <= in_q.link_status;
        last_drops    <= drops_s;
      end else begin
        // Keep the count taken from start_count once started is set.
        entry_count <= count_eff;
        slot_cnt    <= slot_eff;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (stage_go && emit) begin
      out_vld <= 1'b1;
    end else if (out_ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go && emit) begin
      out_q.slot            <= slot_ext[SLOT_FIELD_W-1:0];
      out_q.uptime_s        <= div_prod[DIV1000_SHIFT+UPTIME_W-1:DIV1000_SHIFT];
      out_q.heap_sat        <= heap_s;
      out_q.block_sat       <= block_s;
      out_q.rssi_out        <= in_q.signal_strength;
      out_q.status_out      <= in_q.link_status;
      out_q.drops_sat       <= drops_s;
      out_q.entries_written <= count_eff + 32'd1;
    end
  end

  assign out_valid = out_vld;
  assign out_data  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_NEXT(a_count_steps, clk, rst, stage_go && emit, entry_count == $past(count_eff) + 32'd1, "entry count did not advance on an entry")
  `ASSERT_ALWAYS(a_slot_range, clk, rst, !started || slot_cnt < SLOT_W'(RING_SLOTS - 1) || slot_cnt == SLOT_W'(RING_SLOTS - 1), "ring slot beyond ring size")
  `ASSERT_NEXT(a_started_after_take, clk, rst, stage_go && take, started, "logger not started after an accepted sample")
  `ASSERT_NEXT(a_in_hold, clk, rst, in_vld && !stage_go, in_vld && $stable(in_q), "held sample lost or changed")
  `ASSERT_NEXT(a_out_hold, clk, rst, out_vld && !out_ready, out_vld && $stable(out_q), "pending entry overwritten")

endmodule
